/* src/assert_macros.svh */
// Assertion macros shared by the blend core RTL.
// Bodies collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCCB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TCCB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCB_ASSERT(lbl, prop, msg)
`define TCCB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/tccb_pkg.sv */
// Types and constants of the two-concentration color blend core.
// Used by every module of the block; depends on nothing.
package tccb_pkg;
	localparam int GRID  = 200;
	localparam int LVL_W = 8;
	localparam int CH_W  = 8;
	localparam int SQ_W  = 16;
	localparam int DEN_W = 17;
	localparam int P_W   = 25;
	localparam int CD_W  = 32;
	localparam int DV_W  = 32;
	localparam int NUM_W = 40;
	localparam int CFG_W = 24;
	localparam int IDX_W = 2;

	localparam logic [LVL_W-1:0] GRID_L = LVL_W'(GRID);
	localparam logic [SQ_W-1:0]  NSQ    = SQ_W'(GRID * GRID);

	localparam logic [IDX_W-1:0] REG_EMPTY = 2'd0;
	localparam logic [IDX_W-1:0] REG_A     = 2'd1;
	localparam logic [IDX_W-1:0] REG_B     = 2'd2;
	localparam logic [IDX_W-1:0] REG_BOTH  = 2'd3;

	typedef logic [2:0][CH_W-1:0] color_t;

	typedef struct packed {
		logic [LVL_W-1:0] a_level;
		logic [LVL_W-1:0] b_level;
	} in_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} out_t;

	typedef struct packed {
		color_t empty;
		color_t a_full;
		color_t b_full;
		color_t both_full;
	} colors_t;

	typedef struct packed {
		logic [2:0][NUM_W-1:0] rem;
		logic [2:0][CH_W-1:0]  q;
		logic [DV_W-1:0]       dv;
		color_t                ccol;
		logic                  byp;
	} div_t;
endpackage

/* src/tccb_weight.sv */
// Weight and numerator pipeline, stages one to four of the blend core.
// Depends on tccb_pkg.
module tccb_weight import tccb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    v_in,
	input  in_t     in_data,
	input  colors_t colors,
	output logic    v_s4,
	output div_t    div_s4
);
	logic [LVL_W-1:0] ia, ib, d, ma, mb;
	logic [LVL_W:0]   sum;
	logic             lo;

	logic             v_s1, v_s2, v_s3;
	logic [SQ_W-1:0]  corner_s1, wa_s1, wb_s1;
	color_t           ccol_s1, ccol_s2, ccol_s3;
	logic             byp_s1, byp_s2, byp_s3;

	logic [SQ_W-1:0]      corner_s2, nc_s2, nc_s3;
	logic [DEN_W-1:0]     den_s2;
	logic [2:0][P_W-1:0]  p_s2, p_s3;
	logic [CD_W-1:0]      cd_s3;
	logic [DV_W-1:0]      dv_s3;

	always_comb begin
		ia  = (in_data.a_level > GRID_L) ? GRID_L : in_data.a_level;
		ib  = (in_data.b_level > GRID_L) ? GRID_L : in_data.b_level;
		sum = {1'b0, ia} + {1'b0, ib};
		lo  = sum < {1'b0, GRID_L};
		d   = lo ? LVL_W'({1'b0, GRID_L} - sum) : LVL_W'(sum - {1'b0, GRID_L});
		ma  = lo ? ia : GRID_L - ib;
		mb  = lo ? ib : GRID_L - ia;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corner_s1 <= SQ_W'(d) * SQ_W'(d);
			wa_s1     <= SQ_W'(ma) * SQ_W'(ma);
			wb_s1     <= SQ_W'(mb) * SQ_W'(mb);
			ccol_s1   <= lo ? colors.empty : colors.both_full;
			byp_s1    <= (ia == '0 && ib == '0) || (ia == GRID_L && ib == GRID_L);

			corner_s2 <= corner_s1;
			den_s2    <= DEN_W'(wa_s1) + DEN_W'(wb_s1);
			nc_s2     <= NSQ - corner_s1;
			for (int c = 0; c < 3; c++) begin
				p_s2[c] <= P_W'(colors.a_full[c]) * P_W'(wa_s1)
				         + P_W'(colors.b_full[c]) * P_W'(wb_s1);
			end
			ccol_s2   <= ccol_s1;
			byp_s2    <= byp_s1;

			cd_s3     <= CD_W'(corner_s2) * CD_W'(den_s2);
			dv_s3     <= DV_W'(NSQ) * DV_W'(den_s2);
			p_s3      <= p_s2;
			nc_s3     <= nc_s2;
			ccol_s3   <= ccol_s2;
			byp_s3    <= byp_s2;

			for (int c = 0; c < 3; c++) begin
				div_s4.rem[c] <= NUM_W'(ccol_s3[c]) * NUM_W'(cd_s3)
				               + NUM_W'(p_s3[c]) * NUM_W'(nc_s3);
			end
			div_s4.q    <= '0;
			div_s4.dv   <= dv_s3;
			div_s4.ccol <= ccol_s3;
			div_s4.byp  <= byp_s3;
		end
	end
endmodule

/* src/tccb_div_stage.sv */
// One registered divider stage: two quotient bits for each color channel.
// Depends on tccb_pkg.
module tccb_div_stage import tccb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  div_t d_in,
	output logic v_out,
	output div_t d_out
);
	div_t             nxt;
	logic [NUM_W-1:0] dsh;

	always_comb begin
		nxt = d_in;
		dsh = {1'b0, d_in.dv, 7'b0};
		for (int c = 0; c < 3; c++) begin
			for (int s = 0; s < 2; s++) begin
				if (nxt.rem[c] >= dsh) begin
					nxt.rem[c] = nxt.rem[c] - dsh;
					nxt.q[c]   = {nxt.q[c][CH_W-2:0], 1'b1};
				end else begin
					nxt.q[c]   = {nxt.q[c][CH_W-2:0], 1'b0};
				end
				nxt.rem[c] = {nxt.rem[c][NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

/* src/two_concentration_color_blend_core.sv */
// Top level of the two-concentration color blend core.
// Depends on tccb_pkg, tccb_weight, tccb_div_stage and assert_macros.svh.
//
//  channel  signals                         beat
//  input    in_valid / in_ready / in_data   a_level, b_level
//  output   out_valid / out_ready / out_data red, green, blue
//  config   cfg_we / cfg_index / cfg_data   one 24-bit corner color
//
// Eight register stages: four for weights and numerators, four for the
// divider at two quotient bits each. One beat per cycle while the output is not stalled.
// Reset clears the valid bits and loads the default corner colors.
// A stalled output freezes every stage together; nothing is lost.
`include "assert_macros.svh"
module two_concentration_color_blend_core import tccb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	colors_t    colors_q;
	logic       en;
	logic [4:0] v_d;
	div_t       d_d [5];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q.empty     <= 24'h000000;
			colors_q.a_full    <= 24'hFF0000;
			colors_q.b_full    <= 24'hFFFF00;
			colors_q.both_full <= 24'hFFFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EMPTY: colors_q.empty     <= cfg_data;
				REG_A:     colors_q.a_full    <= cfg_data;
				REG_B:     colors_q.b_full    <= cfg_data;
				REG_BOTH:  colors_q.both_full <= cfg_data;
				default:   colors_q.empty     <= colors_q.empty;
			endcase
		end
	end

	tccb_weight u_weight (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (in_valid),
		.in_data (in_data),
		.colors  (colors_q),
		.v_s4    (v_d[0]),
		.div_s4  (d_d[0])
	);

	for (genvar g = 0; g < 4; g++) begin : g_div
		tccb_div_stage u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (v_d[g]),
			.d_in   (d_d[g]),
			.v_out  (v_d[g+1]),
			.d_out  (d_d[g+1])
		);
	end

	assign out_valid      = v_d[4];
	assign out_data.red   = d_d[4].byp ? d_d[4].ccol[2] : d_d[4].q[2];
	assign out_data.green = d_d[4].byp ? d_d[4].ccol[1] : d_d[4].q[1];
	assign out_data.blue  = d_d[4].byp ? d_d[4].ccol[0] : d_d[4].q[0];

	`TCCB_ASSERT(a_ready_follows_out, in_ready == (!out_valid || out_ready), "ready mismatch")
	`TCCB_ASSERT(a_enter_s1, in_valid && in_ready |=> u_weight.v_s1, "beat lost at entry")
	`TCCB_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid, "stalled beat dropped")
	`TCCB_ASSERT(a_rem_bound, out_valid && !d_d[4].byp |-> d_d[4].rem[0] < {d_d[4].dv, 8'b0}, "divider remainder out of range")
endmodule

/* verif/tb_two_concentration_color_blend_core.sv */
// Self-checking bench for two_concentration_color_blend_core: drives level pairs and
// corner colors, predicts each blended pixel and compares it with the core's output.
// Depends on tccb_pkg and the core RTL only.
module tb_two_concentration_color_blend_core import tccb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready;
	out_t             out_data;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic [CFG_W-1:0] corner_color [4];
	out_t             pixel_q [$];
	int               errors;
	int               pixels_checked;
	int               beats_sent;
	int               color_writes;
	bit               no_idle;
	int               hold_cycles;

	two_concentration_color_blend_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic out_t blend_pixel(in_t lv);
		longint unsigned g, n, i, j, cdist, wa, wb, den, num;
		logic [CFG_W-1:0] ccol;
		logic [7:0]       ch [3];
		out_t             px;
		g = GRID;
		n = g * g;
		i = (lv.a_level > g) ? g : lv.a_level;
		j = (lv.b_level > g) ? g : lv.b_level;
		if (i == 0 && j == 0) begin
			ccol = corner_color[REG_EMPTY];
			px = {ccol[23:16], ccol[15:8], ccol[7:0]};
			return px;
		end
		if (i == g && j == g) begin
			ccol = corner_color[REG_BOTH];
			px = {ccol[23:16], ccol[15:8], ccol[7:0]};
			return px;
		end
		if (i + j < g) begin
			cdist = (g - i - j) * (g - i - j);
			wa = i * i;
			wb = j * j;
			ccol = corner_color[REG_EMPTY];
		end else begin
			cdist = (i + j - g) * (i + j - g);
			wa = (g - j) * (g - j);
			wb = (g - i) * (g - i);
			ccol = corner_color[REG_BOTH];
		end
		den = wa + wb;
		for (int k = 0; k < 3; k++) begin
			int sh;
			sh = 16 - 8 * k;
			num = ((ccol >> sh) & 8'hFF) * cdist * den
				+ (((corner_color[REG_A] >> sh) & 8'hFF) * wa
				+ ((corner_color[REG_B] >> sh) & 8'hFF) * wb) * (n - cdist);
			ch[k] = 8'(num / (n * den));
		end
		px.red = ch[0];
		px.green = ch[1];
		px.blue = ch[2];
		return px;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// expectation on each accepted input beat
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			pixel_q.push_back(blend_pixel(in_data));
			beats_sent++;
		end
	end

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin
		out_t exp_px;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected output beat %h", out_data);
				errors++;
			end else begin
				exp_px = pixel_q.pop_front();
				pixels_checked++;
				if (out_data.red !== exp_px.red) begin
					$error("red: expected %0d, got %0d", exp_px.red, out_data.red);
					errors++;
				end
				if (out_data.green !== exp_px.green) begin
					$error("green: expected %0d, got %0d", exp_px.green, out_data.green);
					errors++;
				end
				if (out_data.blue !== exp_px.blue) begin
					$error("blue: expected %0d, got %0d", exp_px.blue, out_data.blue);
					errors++;
				end
			end
		end
	end

	// receiver stalls: a fresh draw after every accepted beat
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			hold_cycles = no_idle ? 0 : $urandom_range(0, 12);
			out_ready <= (hold_cycles == 0);
		end else if (hold_cycles > 0) begin
			hold_cycles--;
			out_ready <= (hold_cycles == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_beat(input logic [7:0] a, input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{a_level: a, b_level: b};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (pixel_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
	endtask

	task automatic write_color(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] rgb);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= rgb;
		@(posedge clk);
		cfg_we <= 1'b0;
		corner_color[idx] = rgb;
		color_writes++;
	endtask

	task automatic load_palette(input logic [CFG_W-1:0] e, input logic [CFG_W-1:0] ca,
			input logic [CFG_W-1:0] cb, input logic [CFG_W-1:0] cboth);
		drain();
		write_color(REG_EMPTY, e);
		write_color(REG_A, ca);
		write_color(REG_B, cb);
		write_color(REG_BOTH, cboth);
	endtask

	task automatic test_directed();
		logic [7:0] pairs [22][2] = '{
			'{0, 0}, '{200, 200}, '{255, 255}, '{201, 255}, '{0, 255}, '{255, 0},
			'{1, 0}, '{0, 1}, '{200, 0}, '{0, 200}, '{199, 0}, '{100, 100},
			'{100, 99}, '{99, 100}, '{199, 200}, '{200, 199}, '{1, 1}, '{128, 127},
			'{170, 85}, '{201, 3}, '{3, 220}, '{255, 200}
		};
		foreach (pairs[k]) send_beat(pairs[k][0], pairs[k][1]);
	endtask

	task automatic test_random(input int count);
		logic [7:0] a, b;
		for (int k = 0; k < count; k++) begin
			if (k % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				a = 8'($urandom_range(0, 255));
				b = 8'($urandom_range(0, 255));
			end else begin
				a = 8'($urandom_range(0, GRID));
				b = 8'($urandom_range(0, GRID));
			end
			send_beat(a, b);
		end
		no_idle = 0;
	endtask

	task automatic test_palettes();
		load_palette(24'h000000, 24'h000000, 24'h000000, 24'h000000);
		test_directed();
		load_palette(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		test_directed();
		load_palette(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
		test_random(100);
		load_palette(24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h808080);
		test_random(100);
		for (int p = 0; p < 6; p++) begin
			load_palette(CFG_W'($urandom_range(0, 24'hFFFFFF)),
				CFG_W'($urandom_range(0, 24'hFFFFFF)),
				CFG_W'($urandom_range(0, 24'hFFFFFF)),
				CFG_W'($urandom_range(0, 24'hFFFFFF)));
			test_random(200);
		end
	endtask

	task automatic test_pressure();
		for (int k = 0; k < 5; k++) begin
			send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		pixels_checked = 0;
		beats_sent = 0;
		color_writes = 0;
		no_idle = 0;
		hold_cycles = 0;
		corner_color[REG_EMPTY] = 24'h000000;
		corner_color[REG_A] = 24'hFF0000;
		corner_color[REG_B] = 24'hFFFF00;
		corner_color[REG_BOTH] = 24'hFFFFFF;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200);
		test_pressure();
		test_palettes();
		drain();
		$display("Covered %0d beats, %0d checked pixels, %0d color writes over ten palettes.",
			beats_sent, pixels_checked, color_writes);
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
